@@ src/slcg_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package slcg_pkg;

	localparam int unsigned VAL_W       = 20;
	localparam int unsigned SEED_W      = 24;
	localparam int unsigned LCG_MOD     = 714025;
	localparam int unsigned LCG_MUL     = 1366;
	localparam int unsigned LCG_INC     = 150889;
	localparam int unsigned TABLE_DEPTH = 97;
	localparam int unsigned TBL_AW      = $clog2(TABLE_DEPTH);
	localparam int unsigned FILL_CW     = $clog2(TABLE_DEPTH + 1);

	// operand of the constant divider and its quotient
	localparam int unsigned V_W       = 31;
	localparam int unsigned Q_W       = 12;
	localparam int unsigned RECIP_SH  = 50;
	localparam logic [V_W-1:0] LCG_RECIP = V_W'((64'd1 << RECIP_SH) / 64'(LCG_MOD));

	typedef enum logic [1:0] {
		MP_STEP,
		MP_SEED,
		MP_SLOT
	} mp_mode_t;

	typedef struct packed {
		logic              valid;
		mp_mode_t          mode;
		logic [SEED_W-1:0] opnd;
	} mp_req_t;

	typedef struct packed {
		logic             valid;
		logic [Q_W-1:0]   quo;
		logic [VAL_W-1:0] rem;
	} mp_rsp_t;

endpackage

`default_nettype wire

@@ src/shuffled_lcg_random_source_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// channel  direction  signals                          word
// cfg      in         cfg_valid cfg_ready cfg_data      seed, 24 bits
// in       in         in_valid in_ready kind modulus   kind 1 bit, modulus 20 bits
// out      out        out_valid out_ready raw_value    raw 20 bits, reduced 20 bits
//                     reduced_value
//
// a draw holds in_ready low until its result is loaded into the output register,
// through the one-bit-a-cycle remainder unit, which a zero modulus skips
// a restart runs 98 generator steps, one at a time, through the 4-stage mod
// 714025 pipeline, plus the seed reduction; no result
// after reset the block runs a restart from seed 1 before in_ready rises
// a held output word does not stop input; a finished draw waits for the slot

module shuffled_lcg_random_source_core (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cfg_valid,
	output logic                         cfg_ready,
	input  wire  [slcg_pkg::SEED_W-1:0]  cfg_data,
	input  wire                          in_valid,
	output logic                         in_ready,
	input  wire                          kind,
	input  wire  [slcg_pkg::VAL_W-1:0]   modulus,
	output logic                         out_valid,
	input  wire                          out_ready,
	output logic [slcg_pkg::VAL_W-1:0]   raw_value,
	output logic [slcg_pkg::VAL_W-1:0]   reduced_value
);
	import slcg_pkg::*;

	typedef enum logic [3:0] {
		ST_SEED,
		ST_SEED_WAIT,
		ST_FILL_ISSUE,
		ST_FILL_WAIT,
		ST_IDLE,
		ST_SLOT_ISSUE,
		ST_SLOT_WAIT,
		ST_READ,
		ST_RDATA,
		ST_STEP_WAIT,
		ST_DIV_WAIT
	} state_t;

	state_t              state_q;
	logic [SEED_W-1:0]   seed_q;
	logic [VAL_W-1:0]    mixer_q, selector_q, mod_q, raw_q;
	logic [FILL_CW-1:0]  fill_q;
	logic [TBL_AW-1:0]   slot_q;
	logic                out_valid_q;
	logic [VAL_W-1:0]    out_raw_q, out_red_q;

	logic [VAL_W-1:0]    tbl_mem [TABLE_DEPTH];
	logic [VAL_W-1:0]    rd_data_q;
	logic                wr_en;
	logic [TBL_AW-1:0]   wr_addr;

	mp_req_t             mp_req;
	mp_rsp_t             mp_rsp;
	logic                div_start, div_busy;
	logic [VAL_W-1:0]    div_rem;
	logic                in_acc, out_load, fill_done;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign fill_done = (fill_q == FILL_CW'(TABLE_DEPTH));
	assign out_load  = (state_q == ST_DIV_WAIT) && !div_busy && (!out_valid_q || out_ready);
	assign div_start = (state_q == ST_RDATA);

	always_comb begin
		mp_req.valid = 1'b0;
		mp_req.mode  = MP_STEP;
		mp_req.opnd  = SEED_W'(mixer_q);
		unique case (state_q)
			ST_SEED: begin
				mp_req.valid = 1'b1;
				mp_req.mode  = MP_SEED;
				mp_req.opnd  = seed_q;
			end
			ST_FILL_ISSUE: begin
				mp_req.valid = 1'b1;
			end
			ST_SLOT_ISSUE: begin
				mp_req.valid = 1'b1;
				mp_req.mode  = MP_SLOT;
				mp_req.opnd  = SEED_W'(selector_q);
			end
			// next generator value goes in as the slot comes out
			ST_SLOT_WAIT: begin
				mp_req.valid = mp_rsp.valid;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = slot_q;
		if (state_q == ST_FILL_WAIT) begin
			wr_en   = mp_rsp.valid && !fill_done;
			wr_addr = fill_q[TBL_AW-1:0];
		end else if (state_q == ST_STEP_WAIT) begin
			wr_en   = mp_rsp.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			tbl_mem[wr_addr] <= mp_rsp.rem;
		end
		rd_data_q <= tbl_mem[slot_q];
	end

	slcg_mod_pipe u_mod_pipe (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mp_req),
		.rsp    (mp_rsp)
	);

	// the table word is taken straight from the read register as the divide starts
	slcg_rem_div u_rem_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (rd_data_q),
		.divisor   (mod_q),
		.busy      (div_busy),
		.remainder (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_SEED;
			seed_q      <= SEED_W'(1);
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				seed_q <= cfg_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_SEED: begin
					fill_q  <= '0;
					state_q <= ST_SEED_WAIT;
				end
				ST_SEED_WAIT: begin
					if (mp_rsp.valid) begin
						state_q <= ST_FILL_ISSUE;
					end
				end
				ST_FILL_ISSUE: begin
					state_q <= ST_FILL_WAIT;
				end
				ST_FILL_WAIT: begin
					if (mp_rsp.valid) begin
						if (fill_done) begin
							state_q <= ST_IDLE;
						end else begin
							fill_q  <= fill_q + FILL_CW'(1);
							state_q <= ST_FILL_ISSUE;
						end
					end
				end
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= kind ? ST_SEED : ST_SLOT_ISSUE;
					end
				end
				ST_SLOT_ISSUE: begin
					state_q <= ST_SLOT_WAIT;
				end
				ST_SLOT_WAIT: begin
					if (mp_rsp.valid) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_RDATA;
				end
				ST_RDATA: begin
					state_q <= ST_STEP_WAIT;
				end
				ST_STEP_WAIT: begin
					if (mp_rsp.valid) begin
						state_q <= ST_DIV_WAIT;
					end
				end
				ST_DIV_WAIT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_SEED;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_acc) begin
			mod_q <= modulus;
		end
		if (mp_rsp.valid && (state_q == ST_SEED_WAIT || state_q == ST_FILL_WAIT ||
				state_q == ST_STEP_WAIT)) begin
			mixer_q <= mp_rsp.rem;
		end
		if (state_q == ST_FILL_WAIT && mp_rsp.valid && fill_done) begin
			selector_q <= mp_rsp.rem;
		end
		if (state_q == ST_SLOT_WAIT && mp_rsp.valid) begin
			slot_q <= (mp_rsp.quo >= Q_W'(TABLE_DEPTH)) ? TBL_AW'(TABLE_DEPTH - 1)
				: mp_rsp.quo[TBL_AW-1:0];
		end
		if (state_q == ST_RDATA) begin
			raw_q      <= rd_data_q;
			selector_q <= rd_data_q;
		end
		if (out_load) begin
			out_raw_q <= raw_q;
			out_red_q <= div_rem;
		end
	end

	assign out_valid     = out_valid_q;
	assign raw_value     = out_raw_q;
	assign reduced_value = out_red_q;

endmodule

`default_nettype wire

@@ src/slcg_mod_pipe.sv @@
`timescale 1ns / 1ps
`default_nettype none

module slcg_mod_pipe (
	input  wire                 clk,
	input  wire                 arst_n,
	input  slcg_pkg::mp_req_t   req,
	output slcg_pkg::mp_rsp_t   rsp
);
	import slcg_pkg::*;

	logic                 vld_s1, vld_s2, vld_s3, vld_s4;
	logic [V_W-1:0]       v_s1, v_s2, v_s3;
	logic [Q_W-1:0]       q_s2, q_s3, q_s4;
	logic [Q_W+VAL_W-1:0] p_s3;
	logic [VAL_W-1:0]     r_s4;
	logic [V_W-1:0]       v_in;
	logic [2*V_W-1:0]     recip_prod;
	logic [V_W-1:0]       diff;

	always_comb begin
		unique case (req.mode)
			MP_STEP: v_in = V_W'(req.opnd[VAL_W-1:0]) * V_W'(LCG_MUL) + V_W'(LCG_INC);
			MP_SEED: v_in = V_W'(req.opnd) + V_W'(LCG_INC + 1);
			MP_SLOT: v_in = V_W'(req.opnd[VAL_W-1:0]) * V_W'(TABLE_DEPTH);
			default: v_in = '0;
		endcase
	end

	// quotient estimate by reciprocal, low by at most one
	assign recip_prod = (2*V_W)'(v_s1) * (2*V_W)'(LCG_RECIP);
	assign diff       = v_s3 - V_W'(p_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= req.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		v_s1 <= v_in;
		v_s2 <= v_s1;
		q_s2 <= recip_prod[RECIP_SH +: Q_W];
		v_s3 <= v_s2;
		q_s3 <= q_s2;
		p_s3 <= (Q_W+VAL_W)'(q_s2) * (Q_W+VAL_W)'(LCG_MOD);
		if (diff >= V_W'(LCG_MOD)) begin
			r_s4 <= VAL_W'(diff - V_W'(LCG_MOD));
			q_s4 <= q_s3 + Q_W'(1);
		end else begin
			r_s4 <= VAL_W'(diff);
			q_s4 <= q_s3;
		end
	end

	assign rsp.valid = vld_s4;
	assign rsp.quo   = q_s4;
	assign rsp.rem   = r_s4;

endmodule

`default_nettype wire

@@ src/slcg_rem_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

module slcg_rem_div (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         start,
	input  wire  [slcg_pkg::VAL_W-1:0]  dividend,
	input  wire  [slcg_pkg::VAL_W-1:0]  divisor,
	output logic                        busy,
	output logic [slcg_pkg::VAL_W-1:0]  remainder
);
	import slcg_pkg::*;

	localparam int unsigned CNT_W = $clog2(VAL_W);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [VAL_W-1:0] dvd_q, dsr_q, rem_q;
	logic [VAL_W:0]   trial;

	assign trial = {rem_q, dvd_q[VAL_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			// zero divisor leaves the value unreduced
			busy_q <= (divisor != '0);
			cnt_q  <= CNT_W'(VAL_W - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	// restoring remainder, one dividend bit a cycle
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= (divisor == '0) ? dividend : '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[VAL_W-2:0], 1'b0};
			if (trial >= {1'b0, dsr_q}) begin
				rem_q <= VAL_W'(trial - {1'b0, dsr_q});
			end else begin
				rem_q <= VAL_W'(trial);
			end
		end
	end

	assign busy      = busy_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

@@ dv/tb_shuffled_lcg_random_source_core.sv @@
`timescale 1ns / 1ps

module tb_shuffled_lcg_random_source_core;
	import slcg_pkg::*;

	typedef enum logic {
		OP_DRAW    = 1'b0,
		OP_RESTART = 1'b1
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [VAL_W-1:0] modulus;
	} request_t;

	typedef struct packed {
		logic [VAL_W-1:0] raw;
		logic [VAL_W-1:0] reduced;
		logic [VAL_W-1:0] modulus;
	} draw_t;

	localparam int SETTLE_CYCLES = 600;
	localparam int CYCLE_LIMIT   = 2000000;
	localparam logic [SEED_W-1:0] SEED_MIXER_ZERO = 24'd563135;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [SEED_W-1:0]   cfg_data = '0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic                kind = 1'b0;
	logic [VAL_W-1:0]    modulus = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [VAL_W-1:0]    raw_value;
	logic [VAL_W-1:0]    reduced_value;

	// shadow generator state
	logic [VAL_W-1:0]  shuffle_copy [TABLE_DEPTH];
	logic [VAL_W-1:0]  mixer_copy;
	logic [VAL_W-1:0]  selector_copy;
	logic [SEED_W-1:0] seed_copy;

	request_t draw_requests [$];
	draw_t    owed_draws [$];

	logic no_idle = 1'b0;
	int   error_count = 0;
	int   draws_checked = 0;
	int   restarts_taken = 0;
	int   seed_writes = 0;
	int   cycle_count = 0;

	shuffled_lcg_random_source_core uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.kind          (kind),
		.modulus       (modulus),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.raw_value     (raw_value),
		.reduced_value (reduced_value)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [VAL_W-1:0] lcg_step(input logic [VAL_W-1:0] x);
		longint unsigned v;
		v = longint'(LCG_MUL) * longint'(x) + longint'(LCG_INC);
		return VAL_W'(v % longint'(LCG_MOD));
	endfunction

	task automatic reseed_generator();
		longint unsigned start;
		start = (longint'(seed_copy) + 1 + longint'(LCG_INC)) % longint'(LCG_MOD);
		mixer_copy = VAL_W'(start);
		for (int k = 0; k < TABLE_DEPTH; k++) begin
			mixer_copy = lcg_step(mixer_copy);
			shuffle_copy[TBL_AW'(k)] = mixer_copy;
		end
		mixer_copy = lcg_step(mixer_copy);
		selector_copy = mixer_copy;
	endtask

	task automatic advance_generator(input logic op, input logic [VAL_W-1:0] m);
		longint unsigned slot;
		logic [TBL_AW-1:0] idx;
		draw_t d;
		if (op == OP_RESTART) begin
			reseed_generator();
			restarts_taken++;
		end else begin
			slot = (longint'(TABLE_DEPTH) * longint'(selector_copy)) / longint'(LCG_MOD);
			if (slot >= TABLE_DEPTH)
				slot = TABLE_DEPTH - 1;
			idx = TBL_AW'(slot);
			d.raw = shuffle_copy[idx];
			d.modulus = m;
			selector_copy = d.raw;
			mixer_copy = lcg_step(mixer_copy);
			shuffle_copy[idx] = mixer_copy;
			// zero modulus passes the value through
			d.reduced = (m == 0) ? d.raw : d.raw % m;
			owed_draws.push_back(d);
		end
	endtask

	task automatic note_error(input string msg);
		error_count++;
		if (error_count <= 10)
			$display("[%0t] %s", $time, msg);
	endtask

	// request driver
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				advance_generator(kind, modulus);
			if (!in_valid || in_ready) begin
				if (draw_requests.size() != 0 && (no_idle || $urandom_range(99) >= 15)) begin
					in_valid <= 1'b1;
					kind <= draw_requests[0].op;
					modulus <= draw_requests[0].modulus;
					void'(draw_requests.pop_front());
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin : watch_results
		draw_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= no_idle || ($urandom_range(99) >= 15);
			if (out_valid && out_ready) begin
				if (owed_draws.size() == 0) begin
					note_error($sformatf("unexpected word raw %0d reduced %0d",
						raw_value, reduced_value));
				end else begin
					want = owed_draws.pop_front();
					draws_checked++;
					if (raw_value !== want.raw || reduced_value !== want.reduced)
						note_error($sformatf(
							"draw %0d mod %0d: raw exp %0d got %0d, reduced exp %0d got %0d",
							draws_checked, want.modulus, want.raw, raw_value,
							want.reduced, reduced_value));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words still owed",
				cycle_count, owed_draws.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic queue_item(input op_t op, input logic [VAL_W-1:0] m);
		draw_requests.push_back(request_t'{op, m});
	endtask

	// wait for all traffic to drain, then cover a restart still in flight
	task automatic settle();
		while (draw_requests.size() != 0 || in_valid || owed_draws.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_seed(input logic [SEED_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		seed_copy = v;
		seed_writes++;
	endtask

	function automatic logic [VAL_W-1:0] pick_modulus();
		case ($urandom_range(9))
			0: return '0;
			1: return VAL_W'($urandom_range(1, 16));
			2: return VAL_W'($urandom);
			3: return VAL_W'(1) << $urandom_range(VAL_W - 1);
			default: return VAL_W'($urandom_range(1, LCG_MOD));
		endcase
	endfunction

	function automatic logic [SEED_W-1:0] pick_seed();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			2: return SEED_MIXER_ZERO;
			3: return SEED_W'(LCG_MOD);
			default: return SEED_W'($urandom);
		endcase
	endfunction

	initial begin
		seed_copy = SEED_W'(1);
		reseed_generator();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// reset state, seed 1
		queue_item(OP_DRAW, '0);
		queue_item(OP_DRAW, VAL_W'(1));
		queue_item(OP_DRAW, VAL_W'(LCG_MOD));
		queue_item(OP_DRAW, '1);
		queue_item(OP_DRAW, VAL_W'(2));
		queue_item(OP_DRAW, VAL_W'(LCG_MOD - 1));
		queue_item(OP_RESTART, '1);
		queue_item(OP_DRAW, '0);
		settle();

		// a seed write alone must not restart the generator
		write_seed('1);
		queue_item(OP_DRAW, VAL_W'(3));
		queue_item(OP_RESTART, '0);
		queue_item(OP_DRAW, '0);
		queue_item(OP_DRAW, VAL_W'(1000));
		settle();

		write_seed('0);
		queue_item(OP_RESTART, VAL_W'(5));
		queue_item(OP_DRAW, VAL_W'(7));
		queue_item(OP_DRAW, VAL_W'(20'h80000));
		queue_item(OP_DRAW, pick_modulus());
		settle();

		// seed that lands the mixer start on zero, back to back restarts
		write_seed(SEED_MIXER_ZERO);
		queue_item(OP_RESTART, VAL_W'(9));
		queue_item(OP_RESTART, '0);
		queue_item(OP_DRAW, VAL_W'(1));
		queue_item(OP_DRAW, pick_modulus());
		queue_item(OP_DRAW, pick_modulus());

		for (int p = 0; p < 8; p++) begin
			settle();
			no_idle = (p == 3);
			write_seed(pick_seed());
			queue_item(OP_RESTART, pick_modulus());
			repeat (99)
				queue_item(($urandom_range(99) < 4) ? OP_RESTART : OP_DRAW, pick_modulus());
		end
		settle();
		no_idle = 1'b0;

		$display("checked %0d draws across %0d restarts and %0d seed writes",
			draws_checked, restarts_taken, seed_writes);
		$display("moduli spanned zero, one, powers of two and values past 714025");
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

@@ shuffled_lcg_random_source_core.f @@
src/slcg_pkg.sv
src/slcg_mod_pipe.sv
src/slcg_rem_div.sv
src/shuffled_lcg_random_source_core.sv
dv/tb_shuffled_lcg_random_source_core.sv
